FILE: sv/gqps_pkg.sv
package gqps_pkg;

  localparam int BYTES_PER_PIXEL = 3;
  localparam int PIXEL_W         = 8 * BYTES_PER_PIXEL;
  localparam int SUM_W           = 32;
  localparam int ROOT_W          = SUM_W / 2;
  localparam int FW_W            = 10;
  localparam int SPP_W           = 11;
  localparam int CFG_W           = 11;
  localparam int CFG_IDX_W       = 1;
  localparam int DIV_STEPS       = SUM_W;
  localparam int SQRT_STEPS      = ROOT_W;
  localparam int CNT_W           = 5;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET = 10'd512;
  localparam logic [SPP_W-1:0] SAMPLES_RESET     = 11'd1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES     = 1'd1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOR = 1'b1;

  typedef enum logic [1:0] {
    SEL_WRITE = 2'd0,
    SEL_READ  = 2'd1,
    SEL_ERROR = 2'd2
  } result_sel_t;

  typedef struct packed {
    logic        load;
    logic        addr_load;
    logic        div_step;
    logic        sqrt_step;
    logic        mem_re;
    logic        out_load;
    result_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic oor;
    logic is_read;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/gqps_ifs.sv
interface gqps_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [8:0]  x;
  logic [8:0]  y;
  logic [31:0] red_sum;
  logic [31:0] green_sum;
  logic [31:0] blue_sum;

  modport source (output valid, action, x, y, red_sum, green_sum, blue_sum, input ready);
  modport sink   (input valid, action, x, y, red_sum, green_sum, blue_sum, output ready);
endinterface

interface gqps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_byte;
  logic [7:0] green_byte;
  logic [7:0] blue_byte;
  logic       status;

  modport source (output valid, red_byte, green_byte, blue_byte, status, input ready);
  modport sink   (input valid, red_byte, green_byte, blue_byte, status, output ready);
endinterface

FILE: sv/gqps_ram.sv
module gqps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic                                           re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: sv/gqps_ctrl.sv
module gqps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gqps_pkg::dp_status_t status,
  output gqps_pkg::dp_cmd_t    cmd
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_SQRT   = 7'b0001000,
    S_READ   = 7'b0010000,
    S_RWAIT  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t                        state, state_next;
  logic [gqps_pkg::CNT_W-1:0]    cnt, cnt_next;
  gqps_pkg::result_sel_t         sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      sel   <= gqps_pkg::SEL_WRITE;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    sel_next      = sel;
    cmd           = '0;
    cmd.sel       = sel;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.addr_load = 1'b1;
        cnt_next      = '0;
        if (status.oor) begin
          sel_next   = gqps_pkg::SEL_ERROR;
          state_next = S_FINISH;
        end else if (status.is_read) begin
          sel_next   = gqps_pkg::SEL_READ;
          state_next = S_READ;
        end else begin
          sel_next   = gqps_pkg::SEL_WRITE;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == gqps_pkg::CNT_W'(gqps_pkg::DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == gqps_pkg::CNT_W'(gqps_pkg::SQRT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        cmd.mem_re = 1'b1;
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

FILE: sv/gqps_dpath.sv
module gqps_dpath #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gqps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gqps_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                action,
  input  logic [8:0]                          x,
  input  logic [8:0]                          y,
  input  logic [gqps_pkg::SUM_W-1:0]          red_sum,
  input  logic [gqps_pkg::SUM_W-1:0]          green_sum,
  input  logic [gqps_pkg::SUM_W-1:0]          blue_sum,
  input  gqps_pkg::dp_cmd_t                   cmd,
  output gqps_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          red_byte,
  output logic [7:0]                          green_byte,
  output logic [7:0]                          blue_byte,
  output logic                                out_status
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (WW > gqps_pkg::FW_W) ? WW : gqps_pkg::FW_W;
  localparam int PW    = ((AW > 9 + WW) ? AW : 9 + WW) + 1;
  localparam int SW    = gqps_pkg::SUM_W;
  localparam int RW    = gqps_pkg::ROOT_W;
  localparam int DW    = gqps_pkg::SPP_W;
  localparam int NL    = gqps_pkg::BYTES_PER_PIXEL;

  // configuration
  logic [gqps_pkg::FW_W-1:0]  frame_width;
  logic [gqps_pkg::SPP_W-1:0] samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= gqps_pkg::FRAME_WIDTH_RESET;
      samples     <= gqps_pkg::SAMPLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gqps_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data[gqps_pkg::FW_W-1:0];
        gqps_pkg::REG_SAMPLES:     samples     <= cfg_data[gqps_pkg::SPP_W-1:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic       act_q;
  logic [8:0] x_q, y_q;

  // per-channel lanes: q holds dividend/quotient, then feeds the root two bits a step
  logic [SW-1:0] q    [NL];
  logic [DW-1:0] drem [NL];
  logic [19:0]   srem [NL];
  logic [RW-1:0] root [NL];
  logic [SW-1:0] sum_in [NL];
  logic [7:0]    lane_byte [NL];

  assign sum_in[0] = red_sum;
  assign sum_in[1] = green_sum;
  assign sum_in[2] = blue_sum;

  logic [DW-1:0] divisor;
  assign divisor = (samples == '0) ? DW'(1) : samples;

  always_ff @(posedge clk) begin
    logic [DW:0]  dt;
    logic [19:0]  st;
    logic [19:0]  trial;
    if (cmd.load) begin
      act_q <= action;
      x_q   <= x;
      y_q   <= y;
    end
    for (int i = 0; i < NL; i++) begin
      dt    = {drem[i], q[i][SW-1]};
      st    = {srem[i][17:0], q[i][SW-1:SW-2]};
      trial = {2'b00, root[i], 2'b01};
      if (cmd.load) begin
        q[i]    <= sum_in[i];
        drem[i] <= '0;
        srem[i] <= '0;
        root[i] <= '0;
      end else if (cmd.div_step) begin
        if (dt >= {1'b0, divisor}) begin
          drem[i] <= DW'(dt - {1'b0, divisor});
          q[i]    <= {q[i][SW-2:0], 1'b1};
        end else begin
          drem[i] <= dt[DW-1:0];
          q[i]    <= {q[i][SW-2:0], 1'b0};
        end
      end else if (cmd.sqrt_step) begin
        q[i] <= {q[i][SW-3:0], 2'b00};
        if (st >= trial) begin
          srem[i] <= st - trial;
          root[i] <= {root[i][RW-2:0], 1'b1};
        end else begin
          srem[i] <= st;
          root[i] <= {root[i][RW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lane_byte[i] = (root[i] > RW'(255)) ? 8'hFF : root[i][7:0];
    end
  end

  // frame width clamped to 1..MAX_WIDTH
  logic [EW-1:0] fw_ext, eff_ext;
  logic [WW-1:0] eff_w;
  assign fw_ext = EW'(frame_width);
  always_comb begin
    if (fw_ext == '0) begin
      eff_ext = EW'(1);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      eff_ext = EW'(MAX_WIDTH);
    end else begin
      eff_ext = fw_ext;
    end
  end
  assign eff_w = eff_ext[WW-1:0];

  logic [PW-1:0] addr_full;
  logic [AW-1:0] addr_q;
  assign addr_full = PW'(x_q) + PW'(y_q) * PW'(eff_w);

  always_ff @(posedge clk) begin
    if (cmd.addr_load) begin
      addr_q <= addr_full[AW-1:0];
    end
  end

  assign status.oor     = (PW'(x_q) >= PW'(eff_w)) || (32'(y_q) >= 32'(MAX_HEIGHT));
  assign status.is_read = (act_q == gqps_pkg::ACT_READ);
  assign status.out_busy = out_valid && !out_ready;

  // pixel store
  logic [gqps_pkg::PIXEL_W-1:0] wdata, rdata;
  logic                         mem_we;
  assign wdata  = {lane_byte[0], lane_byte[1], lane_byte[2]};
  assign mem_we = cmd.out_load && (cmd.sel == gqps_pkg::SEL_WRITE);

  gqps_ram #(
    .WIDTH (gqps_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_q),
    .wdata (wdata),
    .re    (cmd.mem_re),
    .raddr (addr_q),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.sel)
        gqps_pkg::SEL_WRITE: begin
          {red_byte, green_byte, blue_byte} <= wdata;
          out_status <= gqps_pkg::STATUS_OK;
        end
        gqps_pkg::SEL_READ: begin
          {red_byte, green_byte, blue_byte} <= rdata;
          out_status <= gqps_pkg::STATUS_OK;
        end
        default: begin
          {red_byte, green_byte, blue_byte} <= '0;
          out_status <= gqps_pkg::STATUS_OOR;
        end
      endcase
    end
  end
endmodule

FILE: sv/gamma_quantize_pixel_store.sv
// From accept to result valid a write passes check, 32 divide steps, 16 root steps and
// finish; a read passes check, store read, read wait and finish; out of frame, check and finish.
// One item at a time; the next item is taken the cycle after the result is registered,
// so a write occupies the block through the bit-serial divider and root unit.
// Reset: controller idle, frame_width = 512, samples_per_pixel = 1, no result pending.
// The pixel store is not cleared; an entry holds garbage until written.
module gamma_quantize_pixel_store #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gqps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gqps_pkg::CFG_W-1:0]     cfg_data,
  gqps_in_if.sink                        in_ch,
  gqps_out_if.source                     out_ch
);
  gqps_pkg::dp_cmd_t    cmd;
  gqps_pkg::dp_status_t status;

  gqps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gqps_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (in_ch.action),
    .x          (in_ch.x),
    .y          (in_ch.y),
    .red_sum    (in_ch.red_sum),
    .green_sum  (in_ch.green_sum),
    .blue_sum   (in_ch.blue_sum),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .red_byte   (out_ch.red_byte),
    .green_byte (out_ch.green_byte),
    .blue_byte  (out_ch.blue_byte),
    .out_status (out_ch.status)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("new item taken while one is in flight");

  a_rise_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
    else $error("pending result overwritten");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status |->
      out_ch.red_byte == 8'd0 && out_ch.green_byte == 8'd0 && out_ch.blue_byte == 8'd0)
    else $error("out of frame result carries nonzero bytes");
`endif
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  localparam int CFG_IDX_W = gqps_pkg::CFG_IDX_W;
  localparam int CFG_W     = gqps_pkg::CFG_W;

  localparam logic [gqps_pkg::FW_W-1:0]  FRAME_WIDTH_RESET = gqps_pkg::FRAME_WIDTH_RESET;
  localparam logic [gqps_pkg::SPP_W-1:0] SAMPLES_RESET     = gqps_pkg::SAMPLES_RESET;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = gqps_pkg::REG_FRAME_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES     = gqps_pkg::REG_SAMPLES;

  localparam logic ACT_WRITE  = gqps_pkg::ACT_WRITE;
  localparam logic ACT_READ   = gqps_pkg::ACT_READ;
  localparam logic STATUS_OK  = gqps_pkg::STATUS_OK;
  localparam logic STATUS_OOR = gqps_pkg::STATUS_OOR;

  localparam int unsigned STORE_DEPTH = 512 * 512;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 128;
  localparam logic [10:0] PHASE_FW [0:6] = '{11'd512, 11'd1, 11'd0, 11'd1023,
                                             11'd1061, 11'd300, 11'd512};
  localparam logic [10:0] PHASE_SPP [0:6] = '{11'd1, 11'd1, 11'd0, 11'd2047,
                                              11'd1024, 11'd3, 11'd255};

  typedef struct packed {
    logic        action;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [31:0] red_sum;
    logic [31:0] green_sum;
    logic [31:0] blue_sum;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
    logic       status;
  } pix_result_t;

  typedef struct {
    bit          known;
    pix_result_t res;
  } known_answer_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    pix_item_t            it;
    bit                   known;
    pix_result_t          res;
  } script_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gqps_in_if  in_ch();
  gqps_out_if out_ch();

  gamma_quantize_pixel_store dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state, updated at the clock edge where things are accepted
  logic [23:0]   frame_mem [0:STORE_DEPTH-1];
  logic [10:0]   cur_width_cfg;
  logic [10:0]   cur_spp_cfg;
  pix_result_t   pixel_expect_q [$];
  known_answer_t known_answer_q [$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;

  // stimulus side bookkeeping
  logic [10:0]   drv_width_cfg = FRAME_WIDTH_RESET;
  logic [10:0]   drv_spp_cfg = SAMPLES_RESET;
  bit            stim_written [0:STORE_DEPTH-1];
  int unsigned   stim_addrs [$];
  int unsigned   burst_left = 0;
  script_row_t   script_q [$];

  rx_mode_t      rx_mode = RX_OPEN;
  int unsigned   rx_left = 0;
  int unsigned   rx_period = 2;
  int unsigned   rx_tick = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width(input logic [10:0] raw);
    if (raw[9:0] == 0) return 1;
    if (raw[9:0] > 512) return 512;
    return raw[9:0];
  endfunction

  // average, square root, clamp to a byte
  function automatic logic [7:0] gamma_byte(input logic [31:0] sum, input int unsigned spp);
    logic [31:0] mean;
    logic [15:0] root;
    logic [15:0] trial;
    logic [31:0] sq;
    mean = sum / spp;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      sq = {16'd0, trial} * {16'd0, trial};
      if (sq <= mean) root = trial;
    end
    return (root > 16'd255) ? 8'hFF : root[7:0];
  endfunction

  function automatic pix_result_t predict_pixel(input pix_item_t it);
    int unsigned w;
    int unsigned addr;
    int unsigned spp;
    pix_result_t res;
    w = eff_width(cur_width_cfg);
    res = '0;
    if (it.x >= w) begin
      res.status = STATUS_OOR;
      return res;
    end
    addr = it.x + it.y * w;
    if (it.action == ACT_WRITE) begin
      spp = (cur_spp_cfg == 0) ? 1 : cur_spp_cfg;
      frame_mem[addr] = {gamma_byte(it.red_sum, spp), gamma_byte(it.green_sum, spp),
                         gamma_byte(it.blue_sum, spp)};
    end
    res = {frame_mem[addr], STATUS_OK};
    return res;
  endfunction

  function automatic logic [31:0] rand_sum(input int unsigned spp);
    logic [63:0] v;
    int unsigned r;
    case ($urandom_range(0, 9))
      0: v = 64'($urandom());
      1: v = ($urandom_range(0, 1) != 0) ? 64'hFFFF_FFFF : 64'd0;
      2, 3, 4, 5: v = 64'($urandom_range(0, 66000)) * spp + $urandom_range(0, spp - 1);
      default: begin
        // land on or just below a perfect square of the mean
        r = $urandom_range(0, 256);
        v = 64'(r * r) * spp;
        if (v != 0 && $urandom_range(0, 1) == 1) v = v - 1;
      end
    endcase
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
    script_row_t row;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.it = '0;
    row.known = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic script_row_t pix_row(input logic act, input int x, input int y,
                                          input logic [31:0] r, input logic [31:0] g,
                                          input logic [31:0] b);
    script_row_t row;
    row.is_reg = 1'b0;
    row.reg_idx = REG_FRAME_WIDTH;
    row.reg_val = '0;
    row.it = {act, 9'(x), 9'(y), r, g, b};
    row.known = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic script_row_t pix_known(input logic act, input int x, input int y,
                                            input logic [31:0] r, input logic [31:0] g,
                                            input logic [31:0] b, input logic [23:0] rgb,
                                            input logic st);
    script_row_t row;
    row = pix_row(act, x, y, r, g, b);
    row.known = 1'b1;
    row.res = {rgb, st};
    return row;
  endfunction

  task automatic send_pixel(input pix_item_t it, input bit known, input pix_result_t typed);
    int unsigned w;
    int unsigned addr;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 8);
    end
    w = eff_width(drv_width_cfg);
    if (it.action == ACT_WRITE && it.x < w) begin
      addr = it.x + it.y * w;
      if (!stim_written[addr]) begin
        stim_written[addr] = 1'b1;
        stim_addrs.push_back(addr);
      end
    end
    known_answer_q.push_back('{known, typed});
    in_ch.valid     <= 1'b1;
    in_ch.action    <= it.action;
    in_ch.x         <= it.x;
    in_ch.y         <= it.y;
    in_ch.red_sum   <= it.red_sum;
    in_ch.green_sum <= it.green_sum;
    in_ch.blue_sum  <= it.blue_sum;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // hold off the sender until every pending pixel has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pixel_expect_q.size() != 0 || known_answer_q.size() != 0);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) drv_width_cfg = val;
    else drv_spp_cfg = val;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    pix_item_t     it;
    pix_result_t   got;
    pix_result_t   want;
    known_answer_t ka;
    quiet_cycles++;
    if (rst) begin
      cur_width_cfg = FRAME_WIDTH_RESET;
      cur_spp_cfg = SAMPLES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) cur_width_cfg = cfg_data;
      else if (cfg_index == REG_SAMPLES) cur_spp_cfg = cfg_data;
    end
    if (!rst && in_ch.valid && in_ch.ready) begin
      quiet_cycles = 0;
      it = {in_ch.action, in_ch.x, in_ch.y, in_ch.red_sum, in_ch.green_sum, in_ch.blue_sum};
      ka.known = 1'b0;
      ka.res = '0;
      if (known_answer_q.size() != 0) ka = known_answer_q.pop_front();
      want = predict_pixel(it);
      pixel_expect_q.push_back(ka.known ? ka.res : want);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      quiet_cycles = 0;
      got = {out_ch.red_byte, out_ch.green_byte, out_ch.blue_byte, out_ch.status};
      if (pixel_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: rgb %0d %0d %0d status %0d",
                   got.red_byte, got.green_byte, got.blue_byte, got.status);
      end else begin
        want = pixel_expect_q.pop_front();
        check_field("red_byte", want.red_byte, got.red_byte);
        check_field("green_byte", want.green_byte, got.green_byte);
        check_field("blue_byte", want.blue_byte, got.blue_byte);
        check_field("status", 8'(want.status), 8'(got.status));
      end
    end
    // receiver stall pattern, switching mode every so often
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
      rx_period = $urandom_range(2, 8);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_ch.ready <= 1'b1;
      RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ch.ready <= (rx_tick % rx_period) == 0;
      default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    script_row_t row;
    pix_item_t   it;
    logic [10:0] fw;
    logic [10:0] spp;
    int unsigned w;
    int unsigned s;
    int unsigned addr;
    int unsigned pick;

    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_FRAME_WIDTH;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_WRITE;
    in_ch.x         <= '0;
    in_ch.y         <= '0;
    in_ch.red_sum   <= '0;
    in_ch.green_sum <= '0;
    in_ch.blue_sum  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset config: width 512, one sample
    script_q.push_back(pix_known(ACT_WRITE, 0, 0, 32'd0, 32'd0, 32'd0, 24'h000000, STATUS_OK));
    script_q.push_back(pix_known(ACT_READ, 0, 0, 32'hFFFF_FFFF, 32'd7, 32'd9,
                                 24'h000000, STATUS_OK));
    script_q.push_back(pix_known(ACT_WRITE, 511, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 24'hFFFFFF, STATUS_OK));
    script_q.push_back(pix_known(ACT_READ, 511, 511, 32'd0, 32'd0, 32'd0,
                                 24'hFFFFFF, STATUS_OK));
    // right at and just below 255 squared
    script_q.push_back(pix_known(ACT_WRITE, 1, 0, 32'd65025, 32'd65024, 32'd1,
                                 24'hFFFE01, STATUS_OK));
    script_q.push_back(pix_known(ACT_WRITE, 2, 0, 32'd4, 32'd3, 32'h0001_0000,
                                 24'h0201FF, STATUS_OK));
    script_q.push_back(pix_row(ACT_WRITE, 3, 0, 32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
    // sums on a read are don't-care
    script_q.push_back(pix_known(ACT_READ, 1, 0, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1,
                                 24'hFFFE01, STATUS_OK));
    // zero width behaves as one column
    script_q.push_back(reg_row(REG_FRAME_WIDTH, 11'd0));
    script_q.push_back(pix_row(ACT_WRITE, 0, 5, 32'h0003_0000, 32'h0000_0100, 32'h00FF_0000));
    script_q.push_back(pix_known(ACT_READ, 1, 0, 32'd0, 32'd0, 32'd0, 24'h000000, STATUS_OOR));
    script_q.push_back(pix_row(ACT_WRITE, 0, 511, 32'h0000_FFFF, 32'h8000_0000, 32'h0000_0002));
    // width above the maximum saturates to 512
    script_q.push_back(reg_row(REG_FRAME_WIDTH, 11'd1023));
    script_q.push_back(pix_known(ACT_READ, 511, 511, 32'd0, 32'd0, 32'd0,
                                 24'hFFFFFF, STATUS_OK));
    script_q.push_back(pix_row(ACT_READ, 3, 0, 32'd0, 32'd0, 32'd0));
    script_q.push_back(pix_row(ACT_WRITE, 511, 0, 32'h7FFF_FFFF, 32'h0000_8000, 32'h0100_0000));
    script_q.push_back(reg_row(REG_FRAME_WIDTH, 11'd100));
    script_q.push_back(pix_row(ACT_WRITE, 99, 511, 32'h0040_0000, 32'h0000_0010, 32'h00AB_CDEF));
    script_q.push_back(pix_known(ACT_WRITE, 100, 3, 32'hFFFF_FFFF, 32'd5, 32'd6,
                                 24'h000000, STATUS_OOR));
    script_q.push_back(pix_known(ACT_READ, 511, 0, 32'd0, 32'd0, 32'd0, 24'h000000, STATUS_OOR));
    // zero samples divides by one
    script_q.push_back(reg_row(REG_SAMPLES, 11'd0));
    script_q.push_back(pix_known(ACT_WRITE, 5, 5, 32'd65025, 32'd100, 32'd0,
                                 24'hFF0A00, STATUS_OK));
    script_q.push_back(reg_row(REG_SAMPLES, 11'd2047));
    script_q.push_back(pix_row(ACT_WRITE, 6, 6, 32'hFFFF_FFFF, 32'h1234_5678, 32'd0));
    script_q.push_back(reg_row(REG_SAMPLES, 11'd1024));
    script_q.push_back(pix_known(ACT_WRITE, 7, 7, 32'd1023, 32'd1024, 32'd4194304,
                                 24'h000140, STATUS_OK));
    script_q.push_back(pix_known(ACT_READ, 7, 7, 32'hFFFF_FFFF, 32'd0, 32'd0,
                                 24'h000140, STATUS_OK));

    foreach (script_q[i]) begin
      row = script_q[i];
      if (row.is_reg) begin
        drain();
        reg_write(row.reg_idx, row.reg_val);
      end else begin
        send_pixel(row.it, row.known, row.res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 7) begin
        fw = PHASE_FW[ph];
        spp = PHASE_SPP[ph];
      end else begin
        fw = 11'($urandom_range(0, 2047));
        spp = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                          : 11'($urandom_range(1, 64));
      end
      drain();
      reg_write(REG_FRAME_WIDTH, fw);
      reg_write(REG_SAMPLES, spp);
      w = eff_width(fw);
      s = (spp == 0) ? 1 : spp;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.action = ACT_WRITE;
        it.x = 9'($urandom_range(0, w - 1));
        it.y = 9'($urandom());
        it.red_sum = rand_sum(s);
        it.green_sum = rand_sum(s);
        it.blue_sum = rand_sum(s);
        pick = $urandom_range(0, 99);
        if (pick < 35 && stim_addrs.size() != 0) begin
          // read back something already stored, if it maps into this width
          addr = stim_addrs[$urandom_range(0, stim_addrs.size() - 1)];
          if (addr < 512 * w) begin
            it.action = ACT_READ;
            it.x = 9'(addr % w);
            it.y = 9'(addr / w);
          end
        end else if (pick < 45 && w < 512) begin
          it.action = 1'($urandom());
          it.x = 9'($urandom_range(w, 511));
        end else if (pick < 55) begin
          it.action = 1'($urandom());
          it.x = 9'($urandom());
          if (it.action == ACT_READ && it.x < w && !stim_written[it.x + it.y * w])
            it.action = ACT_WRITE;
        end
        send_pixel(it, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pixel_expect_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
